[src/pkca_pkg.sv]
// ----------------------------------------------------------------------------
// pkca_pkg: shared types and constants of the connection admission table
// Operation codes, status codes, register indexes and limits.
// ----------------------------------------------------------------------------
package pkca_pkg;

	localparam int TABLE_ENTRIES_DEF = 64;
	localparam int KEY_BITS_DEF      = 32;

	localparam logic [2:0] OP_PROBE   = 3'd0;
	localparam logic [2:0] OP_ACQUIRE = 3'd1;
	localparam logic [2:0] OP_START   = 3'd2;
	localparam logic [2:0] OP_END     = 3'd3;
	localparam logic [2:0] OP_EVICT   = 3'd4;
	localparam logic [2:0] OP_TICK    = 3'd5;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_GLOBAL_LIM = 3'd1;
	localparam logic [2:0] ST_HOST_LIM   = 3'd2;
	localparam logic [2:0] ST_FULL       = 3'd3;
	localparam logic [2:0] ST_NOT_ACTIVE = 3'd4;

	localparam logic [1:0] REG_MAX_TOTAL   = 2'd0;
	localparam logic [1:0] REG_MAX_PER_KEY = 2'd1;
	localparam logic [1:0] REG_IDLE_TICKS  = 2'd2;

	localparam logic [15:0] COUNT_MAX = 16'hFFFF;
	localparam logic [6:0]  EVICT_MAX = 7'd127;

	// Result of one operation, held in the engine's result register.
	typedef struct packed {
		logic        granted;
		logic [2:0]  status;
		logic [15:0] total_active;
		logic [15:0] host_active;
		logic [6:0]  evicted;
	} pkca_result_t;

endpackage

[src/pkca_engine.sv]
// ----------------------------------------------------------------------------
// pkca_engine: table memory and sweep sequencer
// Holds entries in a synchronous memory, sweeps them once per probe, acquire,
// start, end or evict operation and writes back at most one chosen entry.
// ----------------------------------------------------------------------------
module pkca_engine #(
	parameter int TABLE_ENTRIES = pkca_pkg::TABLE_ENTRIES_DEF,
	parameter int KEY_BITS      = pkca_pkg::KEY_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [2:0]           operation,
	input  logic [31:0]          host_id,
	input  logic [15:0]          max_total,
	input  logic [15:0]          max_per_key,
	input  logic [31:0]          idle_ticks,
	output logic                 busy,
	output logic                 done,
	output pkca_pkg::pkca_result_t result
);
	import pkca_pkg::*;

	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam logic [CW-1:0] LAST = CW'(TABLE_ENTRIES - 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SWEEP = 3'd1;
	localparam logic [2:0] S_LAST  = 3'd2;
	localparam logic [2:0] S_WRITE = 3'd3;

	typedef struct packed {
		logic [KEY_BITS-1:0] key;
		logic [15:0]         count;
		logic [31:0]         last_tick;
	} entry_t;

	entry_t              mem [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] valid_q;
	entry_t              rd_s1;

	logic [2:0]          state_q;
	logic [CW-1:0]       addr_q;
	logic [IW-1:0]       rd_idx_s1;
	logic [2:0]          op_q;
	logic [KEY_BITS-1:0] key_q;
	logic [15:0]         total_q;
	logic [31:0]         tick_q;
	logic                hit_q;
	logic [IW-1:0]       hit_idx_q;
	entry_t              hit_ent_q;
	logic                free_q;
	logic [IW-1:0]       free_idx_q;
	logic [6:0]          evict_q;
	logic                rd_en;
	logic                chk_s1;

	logic                wr_en;
	logic [IW-1:0]       wr_idx;
	entry_t              wr_data;
	logic                set_valid;

	assign busy  = (state_q != S_IDLE);
	assign rd_en = (state_q == S_SWEEP);

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_s1 <= mem[addr_q[IW-1:0]];
		end
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
	end

	// Outcome of the operation, decided once the sweep has finished.
	logic [15:0] cur_cnt;
	logic        do_wr;
	logic        granted_c;
	logic [2:0]  status_c;
	logic [15:0] new_cnt;
	logic [15:0] new_total;
	logic [IW-1:0] tgt_idx;
	logic        tgt_new;

	always_comb begin
		cur_cnt   = hit_q ? hit_ent_q.count : 16'd0;
		do_wr     = 1'b0;
		granted_c = 1'b0;
		status_c  = ST_OK;
		new_cnt   = cur_cnt;
		new_total = total_q;
		tgt_idx   = hit_q ? hit_idx_q : free_idx_q;
		tgt_new   = !hit_q;
		case (op_q)
			OP_PROBE: begin
				if (total_q >= max_total) status_c = ST_GLOBAL_LIM;
				else if (hit_q && cur_cnt >= max_per_key) status_c = ST_HOST_LIM;
				else granted_c = 1'b1;
			end
			OP_ACQUIRE: begin
				if (total_q >= max_total) status_c = ST_GLOBAL_LIM;
				else if (cur_cnt >= max_per_key) status_c = ST_HOST_LIM;
				else if (!hit_q && !free_q) status_c = ST_FULL;
				else begin
					granted_c = 1'b1;
					do_wr     = 1'b1;
					new_cnt   = cur_cnt + 16'd1;
					new_total = total_q + 16'd1;
				end
			end
			OP_START: begin
				if (!hit_q && !free_q) status_c = ST_FULL;
				else begin
					granted_c = 1'b1;
					do_wr     = 1'b1;
					new_cnt   = (cur_cnt == COUNT_MAX) ? cur_cnt : cur_cnt + 16'd1;
					new_total = (total_q == COUNT_MAX) ? total_q : total_q + 16'd1;
				end
			end
			OP_END: begin
				if (hit_q && cur_cnt != 16'd0) begin
					granted_c = 1'b1;
					do_wr     = 1'b1;
					new_cnt   = cur_cnt - 16'd1;
					new_total = (total_q != 16'd0) ? total_q - 16'd1 : total_q;
				end else begin
					status_c = ST_NOT_ACTIVE;
				end
			end
			default: begin
			end
		endcase
	end

	// Per-entry check on the registered read data.
	logic        k_match;
	logic        idle_old;
	logic [31:0] age;

	assign age      = tick_q - rd_s1.last_tick;
	assign k_match  = valid_q[rd_idx_s1] && (rd_s1.key == key_q);
	assign idle_old = valid_q[rd_idx_s1] && (rd_s1.count == 16'd0) && (age > idle_ticks);

	assign wr_en     = (state_q == S_WRITE) && do_wr;
	assign wr_idx    = tgt_idx;
	assign set_valid = wr_en && tgt_new;
	assign wr_data   = '{key: key_q, count: new_cnt, last_tick: tick_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			total_q <= '0;
			tick_q  <= '0;
			done    <= 1'b0;
			chk_s1  <= 1'b0;
		end else begin
			done   <= 1'b0;
			chk_s1 <= rd_en;
			if (chk_s1 && op_q == OP_EVICT && idle_old) begin
				valid_q[rd_idx_s1] <= 1'b0;
			end
			if (set_valid) begin
				valid_q[wr_idx] <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						if (operation == OP_TICK) begin
							tick_q <= tick_q + 32'd1;
							done   <= 1'b1;
						end else if (operation > OP_TICK) begin
							done <= 1'b1;
						end else begin
							state_q <= S_SWEEP;
						end
					end
				end
				S_SWEEP: begin
					if (addr_q == LAST) state_q <= S_LAST;
				end
				S_LAST: state_q <= S_WRITE;
				S_WRITE: begin
					total_q <= new_total;
					done    <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Sweep datapath; no reset needed on these.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			op_q    <= operation;
			key_q   <= KEY_BITS'(host_id);
			addr_q  <= '0;
			hit_q   <= 1'b0;
			free_q  <= 1'b0;
			evict_q <= '0;
		end
		if (rd_en) begin
			addr_q    <= addr_q + CW'(1);
			rd_idx_s1 <= addr_q[IW-1:0];
			if (!free_q && !valid_q[addr_q[IW-1:0]]) begin
				free_q     <= 1'b1;
				free_idx_q <= addr_q[IW-1:0];
			end
		end
		if (chk_s1) begin
			if (!hit_q && k_match) begin
				hit_q     <= 1'b1;
				hit_idx_q <= rd_idx_s1;
				hit_ent_q <= rd_s1;
			end
			if (op_q == OP_EVICT && idle_old && evict_q != EVICT_MAX) begin
				evict_q <= evict_q + 7'd1;
			end
		end
		if (state_q == S_IDLE && start) begin
			result <= '{granted: 1'b0, status: ST_OK, total_active: total_q,
				host_active: 16'd0, evicted: 7'd0};
		end else if (state_q == S_WRITE) begin
			result.granted      <= granted_c;
			result.status       <= status_c;
			result.total_active <= new_total;
			result.host_active  <= (op_q == OP_EVICT) ? 16'd0 :
				((hit_q || do_wr) ? new_cnt : 16'd0);
			result.evicted      <= (op_q == OP_EVICT) ? evict_q : 7'd0;
		end
	end

`ifndef SYNTH
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result shown while busy");
	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> state_q == S_IDLE) else $error("write not followed by idle");
	a_new_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		set_valid |-> !valid_q[wr_idx]) else $error("new entry on a used slot");
	a_total_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WRITE && op_q == OP_START && total_q == COUNT_MAX)
		|=> total_q == COUNT_MAX) else $error("total wrapped");
`endif

endmodule

[src/per_key_connection_admission_table.sv]
// ----------------------------------------------------------------------------
// per_key_connection_admission_table: per-host connection admission control
// Top level: configuration registers and the table engine.
// ----------------------------------------------------------------------------
// An operation is issued by raising start with operation and host_id while
// busy is low; that edge accepts the transaction. Probe, acquire, start, end
// and evict walk every table entry through the single read port of the
// entry memory, one entry a cycle, then pass through S_LAST and S_WRITE,
// which writes back at most one entry and registers the result. Tick and
// unused codes answer at once: their result is registered at acceptance
// and shown in the next cycle. The result appears for exactly one cycle
// with done high; the receiver cannot hold it off and must take it then.
// While the result is shown the block is idle again and may accept the
// next transaction.
// Configuration writes use cfg_valid/cfg_ready with cfg_index and
// cfg_data; cfg_ready is always high, and writes belong to idle periods.
// Reset clears all entries' valid bits at once, the total and the time
// base, and loads the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module per_key_connection_admission_table #(
	parameter int TABLE_ENTRIES = pkca_pkg::TABLE_ENTRIES_DEF,
	parameter int KEY_BITS      = pkca_pkg::KEY_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  operation,
	input  logic [31:0] host_id,
	output logic        done,
	output logic        granted,
	output logic [2:0]  status,
	output logic [15:0] total_active,
	output logic [15:0] host_active,
	output logic [6:0]  evicted,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import pkca_pkg::*;

	logic [15:0]  max_total_q;
	logic [15:0]  max_per_key_q;
	logic [31:0]  idle_ticks_q;
	pkca_result_t res;

	assign cfg_ready = 1'b1;

	// Register writes; an index beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_total_q   <= 16'd64;
			max_per_key_q <= 16'd8;
			idle_ticks_q  <= 32'd1000;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MAX_TOTAL:   max_total_q   <= cfg_data[15:0];
				REG_MAX_PER_KEY: max_per_key_q <= cfg_data[15:0];
				REG_IDLE_TICKS:  idle_ticks_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	pkca_engine #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.KEY_BITS(KEY_BITS)
	) u_engine (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.operation(operation),
		.host_id(host_id),
		.max_total(max_total_q),
		.max_per_key(max_per_key_q),
		.idle_ticks(idle_ticks_q),
		.busy(busy),
		.done(done),
		.result(res)
	);

	assign granted      = res.granted;
	assign status       = res.status;
	assign total_active = res.total_active;
	assign host_active  = res.host_active;
	assign evicted      = res.evicted;

endmodule
